// ===== design/wlp_pkg.sv =====
// Shared types, constants and controller encodings for the latency percentile block.
package wlp_pkg;

    localparam int WINDOW_DEF = 128;
    localparam int FRAC_DEF   = 16;

    localparam int TICK_W    = 64;
    localparam int FREQ_W    = 32;
    localparam int DUR_W     = 32;
    localparam int CNT_OUT_W = 8;

    // 1000 = 2^10 - 2^4 - 2^3, done as shift and subtract
    localparam int SCALE_W    = 10;
    localparam int SCALE_SH_A = 10;
    localparam int SCALE_SH_B = 4;
    localparam int SCALE_SH_C = 3;

    localparam int PCT_MED    = 50;
    localparam int PCT_HI     = 95;
    localparam int RANK_ROUND = 99;
    // floor(x/100) == (x * RECIP) >> RECIP_SH, exact for x < 199728
    localparam int RECIP      = 167773;
    localparam int RECIP_W    = 18;
    localparam int RECIP_SH   = 24;

    typedef enum logic {
        CMD_SUBMIT = 1'b0,
        CMD_CLEAR  = 1'b1
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code          command;
        logic [TICK_W-1:0]  start_ticks;
        logic [TICK_W-1:0]  end_ticks;
        logic [FREQ_W-1:0]  tick_frequency;
        logic               disjoint;
        logic               was_cancelled;
        logic               read_failed;
    } t_in;

    typedef struct packed {
        logic                 accepted;
        logic [CNT_OUT_W-1:0] window_count;
        logic [DUR_W-1:0]     median_ms;
        logic [DUR_W-1:0]     p95_ms;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_RING,
        S_REM,
        S_INS0,
        S_INS,
        S_INSL,
        S_COMMIT,
        S_RANK,
        S_RD50,
        S_RD95,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic div;
        logic ring;
        logic rem;
        logic ins0;
        logic ins;
        logic insl;
        logic commit;
        logic rank;
        logic rd_hi;
        logic cap_med;
        logic out_load;
    } t_ctl;

    typedef struct packed {
        logic go;
        logic div_last;
        logic full;
        logic rem_done;
        logic ins_zero;
        logic ins_gt;
        logic ins_pos_one;
        logic out_free;
    } t_sts;

endpackage

// ===== design/windowed_latency_percentiles_top.sv =====
// Top level of the sliding-window latency percentile block.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one transfer per
// measurement or clear command. Output channel (o_out_valid / i_out_stall /
// o_out_data): exactly one result transfer per input transfer, in order.
// One item is worked at a time; the input stalls until the sequencer is idle.
// Steps per item: a clear or dropped measurement goes straight to the rank
// lookup and the median and 95th percentile reads. An accepted measurement
// first takes the shift-and-subtract multiply and the bit-serial divide (one
// quotient bit per cycle over the 74+FRAC_BITS bit scaled tick count), then
// writes the arrival ring, runs the eviction scan of the sorted memory once
// the window is full and the insertion shift, and then the rank lookup.
// The sorted window memory has one read port and one write port.
// Reset empties the window (count and ring head only; memory contents are
// never read before written). The result sits in an output register; the
// next item is taken while it waits, and the sequencer holds in its final
// state when the receiver stalls with the previous result still pending.
module windowed_latency_percentiles_top #(
    parameter int WINDOW    = wlp_pkg::WINDOW_DEF,
    parameter int FRAC_BITS = wlp_pkg::FRAC_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  wlp_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output wlp_pkg::t_out o_out_data
);
    import wlp_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    // sequencer
    wlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    // divider, window stores, rank lookup and result register
    wlp_dp #(
        .WINDOW    (WINDOW),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== design/wlp_ctrl.sv =====
// Sequencer for the latency percentile block: divide, evict, insert, rank lookup.
module wlp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  wlp_pkg::t_sts i_sts,
    output wlp_pkg::t_ctl o_ctl
);
    import wlp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.go ? S_MUL1 : S_RANK;
                end
            end
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_RING;
                end
            end
            S_RING:   n_state = i_sts.full ? S_REM : S_INS0;
            S_REM: begin
                if (i_sts.rem_done) begin
                    n_state = S_INS0;
                end
            end
            S_INS0:   n_state = i_sts.ins_zero ? S_INSL : S_INS;
            S_INS: begin
                if (!i_sts.ins_gt) begin
                    n_state = S_COMMIT;
                end else if (i_sts.ins_pos_one) begin
                    n_state = S_INSL;
                end
            end
            S_INSL:   n_state = S_COMMIT;
            S_COMMIT: n_state = S_RANK;
            S_RANK:   n_state = S_RD50;
            S_RD50:   n_state = S_RD95;
            S_RD95:   n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl          = '0;
        o_in_stall     = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_ctl.load = i_in_valid;
            end
            S_MUL1:   o_ctl.mul1   = 1'b1;
            S_MUL2:   o_ctl.mul2   = 1'b1;
            S_DIV:    o_ctl.div    = 1'b1;
            S_RING:   o_ctl.ring   = 1'b1;
            S_REM:    o_ctl.rem    = 1'b1;
            S_INS0:   o_ctl.ins0   = 1'b1;
            S_INS:    o_ctl.ins    = 1'b1;
            S_INSL:   o_ctl.insl   = 1'b1;
            S_COMMIT: o_ctl.commit = 1'b1;
            S_RANK:   o_ctl.rank   = 1'b1;
            S_RD50:   o_ctl.rd_hi  = 1'b0;
            S_RD95: begin
                o_ctl.rd_hi   = 1'b1;
                o_ctl.cap_med = 1'b1;
            end
            S_DONE: begin
                o_ctl.rd_hi    = 1'b1;
                o_ctl.out_load = i_sts.out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

// ===== design/wlp_dp.sv =====
// Datapath: duration divider, arrival ring, sorted window memory, rank lookup, output register.
module wlp_dp #(
    parameter int WINDOW    = wlp_pkg::WINDOW_DEF,
    parameter int FRAC_BITS = wlp_pkg::FRAC_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wlp_pkg::t_in  i_in_data,
    input  wlp_pkg::t_ctl i_ctl,
    output wlp_pkg::t_sts o_sts,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output wlp_pkg::t_out o_out_data
);
    import wlp_pkg::*;

    localparam int AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW     = $clog2(WINDOW + 1);
    localparam int PROD_W = TICK_W + SCALE_W;
    localparam int PW     = PROD_W + FRAC_BITS;
    localparam int DCW    = $clog2(PW + 1);
    localparam int RW     = $clog2(PCT_HI * WINDOW + RANK_ROUND + 1);
    localparam int MW     = RW + RECIP_W;

    // item capture
    logic [TICK_W-1:0] r_ticks;
    logic [FREQ_W-1:0] r_freq;
    logic              r_acc;

    // divider
    logic [PROD_W-1:0] r_prod;
    logic [PW-1:0]     r_dvd;
    logic [DUR_W-1:0]  r_rem;
    logic [DUR_W-1:0]  r_q;
    logic              r_sat;
    logic [DCW-1:0]    r_cnt;
    logic [DUR_W:0]    w_rem_sh;
    logic              w_ge;
    logic [DUR_W-1:0]  w_dur;

    // window bookkeeping
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_oldest;
    logic              w_full;
    logic [AW:0]       w_sum;
    logic [AW-1:0]     w_slot;

    // memories
    logic [DUR_W-1:0]  r_arrival [WINDOW];
    logic [DUR_W-1:0]  r_sorted  [WINDOW];
    logic [DUR_W-1:0]  r_old;
    logic [DUR_W-1:0]  r_rdata;
    logic [AW-1:0]     w_raddr;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DUR_W-1:0]  w_wdata;

    // evict scan
    logic [AW-1:0]     r_j;
    logic [AW-1:0]     r_jd;
    logic              r_dv;
    logic              r_found;

    // insert scan
    logic [AW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     w_m;

    // rank
    logic [RW-1:0]     w_x50, w_x95;
    logic [MW-1:0]     w_p50, w_p95;
    logic [AW-1:0]     r_idx50, r_idx95;
    logic [DUR_W-1:0]  r_med;

    t_out              r_out;
    logic              r_ovalid;

    assign w_full = (r_count == CW'(WINDOW));
    assign w_sum  = (AW + 1)'(r_oldest) + (AW + 1)'(r_count);
    assign w_slot = w_full ? r_oldest :
                    ((w_sum >= (AW + 1)'(WINDOW)) ? AW'(w_sum - (AW + 1)'(WINDOW))
                                                  : AW'(w_sum));
    assign w_m    = w_full ? CW'(WINDOW - 1) : r_count;

    // restoring divide step, one quotient bit per cycle
    assign w_rem_sh = {r_rem, r_dvd[PW-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_freq});
    assign w_dur    = r_sat ? '1 : r_q;

    assign w_x50 = RW'(RW'(r_count) * RW'(PCT_MED) + RW'(RANK_ROUND));
    assign w_x95 = RW'(RW'(r_count) * RW'(PCT_HI) + RW'(RANK_ROUND));
    assign w_p50 = MW'(w_x50) * MW'(RECIP);
    assign w_p95 = MW'(w_x95) * MW'(RECIP);

    always_comb begin
        o_sts.go = (i_in_data.command == CMD_SUBMIT) && !i_in_data.disjoint &&
                   !i_in_data.was_cancelled && !i_in_data.read_failed &&
                   (i_in_data.end_ticks >= i_in_data.start_ticks) &&
                   (i_in_data.tick_frequency != '0);
        o_sts.div_last    = (r_cnt == DCW'(1));
        o_sts.full        = w_full;
        o_sts.rem_done    = r_dv && (r_jd == AW'(WINDOW - 1));
        o_sts.ins_zero    = (w_m == '0);
        o_sts.ins_gt      = (r_rdata > w_dur);
        o_sts.ins_pos_one = (r_pos == AW'(1));
        o_sts.out_free    = !r_ovalid || !i_out_stall;
    end

    always_comb begin
        n_pos = r_pos;
        if (i_ctl.ins0) begin
            n_pos = AW'(w_m);
        end else if (i_ctl.ins && o_sts.ins_gt) begin
            n_pos = r_pos - AW'(1);
        end
    end

    always_comb begin
        if (i_ctl.rem) begin
            w_raddr = r_j;
        end else if (i_ctl.ins0 || i_ctl.ins) begin
            w_raddr = n_pos - AW'(1);
        end else begin
            w_raddr = i_ctl.rd_hi ? r_idx95 : r_idx50;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = w_dur;
        if (i_ctl.rem) begin
            w_we    = r_dv && r_found;
            w_waddr = r_jd - AW'(1);
            w_wdata = r_rdata;
        end else if (i_ctl.ins) begin
            w_we    = 1'b1;
            w_waddr = r_pos;
            w_wdata = o_sts.ins_gt ? r_rdata : w_dur;
        end else if (i_ctl.insl) begin
            w_we    = 1'b1;
            w_waddr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_sorted[w_raddr];
        if (w_we) begin
            r_sorted[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ring) begin
            r_old            <= r_arrival[r_oldest];
            r_arrival[w_slot] <= w_dur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ticks <= i_in_data.end_ticks - i_in_data.start_ticks;
            r_freq  <= i_in_data.tick_frequency;
            r_acc   <= o_sts.go;
        end
        if (i_ctl.mul1) begin
            r_prod <= (PROD_W'(r_ticks) << SCALE_SH_A) - (PROD_W'(r_ticks) << SCALE_SH_B);
        end
        if (i_ctl.mul2) begin
            r_dvd <= {r_prod - (PROD_W'(r_ticks) << SCALE_SH_C), {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_q   <= '0;
            r_sat <= 1'b0;
            r_cnt <= DCW'(PW);
        end
        if (i_ctl.div) begin
            r_dvd <= r_dvd << 1;
            r_rem <= w_ge ? DUR_W'(w_rem_sh - {1'b0, r_freq}) : DUR_W'(w_rem_sh);
            r_q   <= {r_q[DUR_W-2:0], w_ge};
            r_sat <= r_sat | r_q[DUR_W-1];
            r_cnt <= r_cnt - DCW'(1);
        end
        if (i_ctl.ring) begin
            r_j     <= '0;
            r_dv    <= 1'b0;
            r_found <= 1'b0;
        end
        if (i_ctl.rem) begin
            r_j  <= r_j + AW'(1);
            r_jd <= r_j;
            r_dv <= 1'b1;
            if (r_dv && !r_found && (r_rdata == r_old)) begin
                r_found <= 1'b1;
            end
        end
        r_pos <= n_pos;
        if (i_ctl.rank) begin
            r_idx50 <= AW'((w_p50 >> RECIP_SH) - MW'(1));
            r_idx95 <= AW'((w_p95 >> RECIP_SH) - MW'(1));
        end
        if (i_ctl.cap_med) begin
            r_med <= r_rdata;
        end
        if (i_ctl.out_load) begin
            r_out.accepted     <= r_acc;
            r_out.window_count <= CNT_OUT_W'(r_count);
            r_out.median_ms    <= (r_count == '0) ? '0 : r_med;
            r_out.p95_ms       <= (r_count == '0) ? '0 : r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_oldest <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ctl.load && (i_in_data.command == CMD_CLEAR)) begin
                r_count  <= '0;
                r_oldest <= '0;
            end else if (i_ctl.commit) begin
                if (w_full) begin
                    r_oldest <= (r_oldest == AW'(WINDOW - 1)) ? '0 : r_oldest + AW'(1);
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_ctl.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(WINDOW))
        else $error("window count beyond capacity");

    a_oldest_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oldest != '0) |-> w_full)
        else $error("ring head moved while window not full");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.out_load && (r_count == '0)) |=>
        (r_out.median_ms == '0 && r_out.p95_ms == '0))
        else $error("empty window reported nonzero percentile");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_out_stall) |-> !i_ctl.out_load)
        else $error("result overwritten while stalled");

endmodule
